@@ sv/opp_pkg.sv @@
// opp_pkg: shared types, symbol codes, precedence table and character classifier
// for the operator precedence parser. No dependencies.
package opp_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int SYM_W       = 4;
   localparam int LIMIT_W     = 10;
   localparam int RED_W       = 8;

   // stack symbol codes
   localparam logic [SYM_W-1:0] SYM_PLUS  = 4'd0;
   localparam logic [SYM_W-1:0] SYM_MINUS = 4'd1;
   localparam logic [SYM_W-1:0] SYM_MUL   = 4'd2;
   localparam logic [SYM_W-1:0] SYM_DIV   = 4'd3;
   localparam logic [SYM_W-1:0] SYM_LP    = 4'd4;
   localparam logic [SYM_W-1:0] SYM_RP    = 4'd5;
   localparam logic [SYM_W-1:0] SYM_ID    = 4'd6;
   localparam logic [SYM_W-1:0] SYM_END   = 4'd7;
   localparam logic [SYM_W-1:0] SYM_E     = 4'd8;

   // input characters
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_MUL   = 8'h2a;
   localparam logic [7:0] CH_DIV   = 8'h2f;
   localparam logic [7:0] CH_LP    = 8'h28;
   localparam logic [7:0] CH_RP    = 8'h29;
   localparam logic [7:0] CH_END   = 8'h23;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_Z     = 8'h7a;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd50;
   localparam logic [LIMIT_W-1:0] COUNT_MAX   = 10'd1023;
   localparam logic [RED_W-1:0]   RED_MAX     = 8'd255;

   typedef enum logic [2:0] {
      REL_NONE = 3'd0,
      REL_LT   = 3'd1,
      REL_EQ   = 3'd2,
      REL_GT   = 3'd3,
      REL_ACC  = 3'd4
   } rel_type;

   typedef enum logic [2:0] {
      ST_SHIFTED     = 3'd0,
      ST_ACCEPTED    = 3'd1,
      ST_BAD_SYMBOL  = 3'd2,
      ST_NO_RELATION = 3'd3,
      ST_NO_REDUCE   = 3'd4,
      ST_STEP_LIMIT  = 3'd5,
      ST_OVERFLOW    = 3'd6,
      ST_DISCARDED   = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD_UP,
      CELL_LOAD_DOWN2
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_RUN
   } state_type;

   typedef struct packed {
      cell_op_type      top_op;
      cell_op_type      rest_op;
      logic [SYM_W-1:0] top_val;
   } cell_ctrl_type;

   typedef struct packed {
      logic       bad;
      logic [2:0] code;
   } class_type;

   // rows: top terminal, columns: incoming symbol, both in code order
   localparam logic [0:63][2:0] REL_TABLE = {
      3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd3,
      3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd0,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd0, 3'd3, 3'd0, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd0, 3'd3, 3'd0, 3'd3,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1, 3'd4
   };

   function automatic rel_type rel_lookup(input logic [2:0] top, input logic [2:0] sym);
      rel_lookup = rel_type'(REL_TABLE[{top, sym}]);
   endfunction

   function automatic class_type classify(input logic [7:0] c);
      class_type r;
      r.bad  = 1'b0;
      r.code = SYM_ID[2:0];
      if (c >= CH_A && c <= CH_Z) begin
         r.code = SYM_ID[2:0];
      end else begin
         case (c)
            CH_PLUS:  r.code = SYM_PLUS[2:0];
            CH_MINUS: r.code = SYM_MINUS[2:0];
            CH_MUL:   r.code = SYM_MUL[2:0];
            CH_DIV:   r.code = SYM_DIV[2:0];
            CH_LP:    r.code = SYM_LP[2:0];
            CH_RP:    r.code = SYM_RP[2:0];
            CH_END:   r.code = SYM_END[2:0];
            default:  r.bad  = 1'b1;
         endcase
      end
      return r;
   endfunction

endpackage

@@ sv/opp_cell.sv @@
// opp_cell: one entry of the shifting symbol stack; cell zero is the top.
// Depends on opp_pkg.
module opp_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  opp_pkg::cell_op_type        op,
   input  logic [opp_pkg::SYM_W-1:0]   up_val,
   input  logic [opp_pkg::SYM_W-1:0]   down2_val,
   output logic [opp_pkg::SYM_W-1:0]   value
);

   logic [opp_pkg::SYM_W-1:0] value_ff;
   logic [opp_pkg::SYM_W-1:0] value_in;

   always_comb begin
      case (op)
         opp_pkg::CELL_HOLD:       value_in = value_ff;
         opp_pkg::CELL_LOAD_UP:    value_in = up_val;
         opp_pkg::CELL_LOAD_DOWN2: value_in = down2_val;
         default:                  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= opp_pkg::SYM_END;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

@@ sv/opp_seq.sv @@
// opp_seq: transaction handshakes, step limit register and the shift/reduce
// sequencer that drives the cell row. Depends on opp_pkg.
module opp_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_symbol,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [opp_pkg::RED_W-1:0]     rsp_reductions,
   input  logic                          csr_wr_en,
   input  logic [opp_pkg::LIMIT_W-1:0]   csr_wr_data,
   input  logic [opp_pkg::SYM_W-1:0]     cell0,
   input  logic [opp_pkg::SYM_W-1:0]     cell1,
   input  logic [opp_pkg::SYM_W-1:0]     cell2,
   output opp_pkg::cell_ctrl_type        ctrl
);

   localparam logic [opp_pkg::SP_W-1:0] SP_MAX = opp_pkg::SP_W'(opp_pkg::STACK_DEPTH - 1);
   localparam logic [opp_pkg::SP_W-1:0] SP_TWO = opp_pkg::SP_W'(2);
   localparam logic [opp_pkg::SP_W-1:0] SP_ONE = opp_pkg::SP_W'(1);

   opp_pkg::state_type            state_ff, state_in;
   logic [2:0]                    sym_ff;
   logic                          bad_ff;
   logic                          end_ff;
   logic                          disc_ff, disc_in;
   logic [opp_pkg::SP_W-1:0]      sp_ff, sp_in;
   logic [opp_pkg::LIMIT_W-1:0]   count_ff, count_in;
   logic [opp_pkg::LIMIT_W-1:0]   limit_ff;
   logic [opp_pkg::RED_W-1:0]     reds_ff, reds_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   opp_pkg::status_type           rsp_status_ff;
   logic [opp_pkg::RED_W-1:0]     rsp_reductions_ff;

   opp_pkg::class_type            cls;
   opp_pkg::rel_type              rel;
   opp_pkg::status_type           status;
   logic [opp_pkg::RED_W-1:0]     reds_out;
   logic [2:0]                    top_term;
   logic [opp_pkg::LIMIT_W-1:0]   count_inc;
   logic [opp_pkg::RED_W-1:0]     reds_inc;
   logic                          out_free;
   logic                          done;
   logic                          commit;
   logic                          accept;
   logic                          reduce_id;
   logic                          reduce_three;

   assign cls       = opp_pkg::classify(req_symbol);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == opp_pkg::FSM_IDLE);
   assign accept    = req_valid && req_ready;
   assign top_term  = (cell0 == opp_pkg::SYM_E) ? cell1[2:0] : cell0[2:0];
   assign rel       = opp_pkg::rel_lookup(top_term, sym_ff);
   assign count_inc = (count_ff == opp_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign reds_inc  = (reds_ff == opp_pkg::RED_MAX) ? reds_ff : reds_ff + 1'b1;
   assign reduce_id = (cell0 == opp_pkg::SYM_ID);
   assign reduce_three = (sp_ff >= SP_TWO) &&
      ((cell0 == opp_pkg::SYM_E && cell1 <= opp_pkg::SYM_DIV && cell2 == opp_pkg::SYM_E) ||
       (cell0 == opp_pkg::SYM_RP && cell1 == opp_pkg::SYM_E && cell2 == opp_pkg::SYM_LP));
   assign commit    = (state_ff == opp_pkg::FSM_RUN) && done && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         opp_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = opp_pkg::FSM_RUN;
            end
         end
         opp_pkg::FSM_RUN: begin
            if (done && out_free) begin
               state_in = opp_pkg::FSM_IDLE;
            end
         end
         default: state_in = opp_pkg::FSM_IDLE;
      endcase
   end

   // one shift or reduce decision per cycle while the output register is free
   always_comb begin
      done         = 1'b0;
      status       = opp_pkg::ST_SHIFTED;
      reds_out     = reds_ff;
      ctrl.top_op  = opp_pkg::CELL_HOLD;
      ctrl.rest_op = opp_pkg::CELL_HOLD;
      ctrl.top_val = cell0;
      sp_in        = sp_ff;
      count_in     = count_ff;
      reds_in      = reds_ff;
      disc_in      = disc_ff;
      if (accept) begin
         reds_in = '0;
      end
      if (state_ff == opp_pkg::FSM_RUN && out_free) begin
         if (disc_ff) begin
            done     = 1'b1;
            status   = opp_pkg::ST_DISCARDED;
            reds_out = '0;
         end else if (bad_ff) begin
            done     = 1'b1;
            status   = opp_pkg::ST_BAD_SYMBOL;
            reds_out = '0;
         end else begin
            case (rel)
               opp_pkg::REL_LT, opp_pkg::REL_EQ: begin
                  done = 1'b1;
                  if (sp_ff == SP_MAX) begin
                     status = opp_pkg::ST_OVERFLOW;
                  end else begin
                     ctrl.top_op  = opp_pkg::CELL_LOAD_UP;
                     ctrl.rest_op = opp_pkg::CELL_LOAD_UP;
                     ctrl.top_val = {1'b0, sym_ff};
                     sp_in        = sp_ff + SP_ONE;
                     count_in     = count_inc;
                     status = (count_inc >= limit_ff) ? opp_pkg::ST_STEP_LIMIT
                                                      : opp_pkg::ST_SHIFTED;
                  end
               end
               opp_pkg::REL_GT: begin
                  if (reduce_id || reduce_three) begin
                     ctrl.top_op  = opp_pkg::CELL_LOAD_UP;
                     ctrl.top_val = opp_pkg::SYM_E;
                     if (!reduce_id) begin
                        ctrl.rest_op = opp_pkg::CELL_LOAD_DOWN2;
                        sp_in        = sp_ff - SP_TWO;
                     end
                     reds_in  = reds_inc;
                     reds_out = reds_inc;
                     count_in = count_inc;
                     if (count_inc >= limit_ff) begin
                        done   = 1'b1;
                        status = opp_pkg::ST_STEP_LIMIT;
                     end
                  end else begin
                     done   = 1'b1;
                     status = opp_pkg::ST_NO_REDUCE;
                  end
               end
               opp_pkg::REL_ACC: begin
                  done   = 1'b1;
                  status = opp_pkg::ST_ACCEPTED;
               end
               default: begin
                  done   = 1'b1;
                  status = opp_pkg::ST_NO_RELATION;
               end
            endcase
         end
         if (done) begin
            if (end_ff) begin
               ctrl.top_op  = opp_pkg::CELL_LOAD_UP;
               ctrl.rest_op = opp_pkg::CELL_HOLD;
               ctrl.top_val = opp_pkg::SYM_END;
               sp_in        = '0;
               count_in     = '0;
               disc_in      = 1'b0;
            end else if (status != opp_pkg::ST_SHIFTED && status != opp_pkg::ST_ACCEPTED) begin
               disc_in = 1'b1;
            end
         end
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= opp_pkg::FSM_IDLE;
         disc_ff      <= 1'b0;
         sp_ff        <= '0;
         count_ff     <= '0;
         reds_ff      <= '0;
         limit_ff     <= opp_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         disc_ff      <= disc_in;
         sp_ff        <= sp_in;
         count_ff     <= count_in;
         reds_ff      <= reds_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sym_ff <= cls.code;
         bad_ff <= cls.bad;
         end_ff <= (req_symbol == opp_pkg::CH_END);
      end
      if (commit) begin
         rsp_status_ff     <= status;
         rsp_reductions_ff <= reds_out;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_reductions = rsp_reductions_ff;

endmodule

@@ sv/operator_precedence_parser.sv @@
// operator_precedence_parser: top level, a row of stack cells and the sequencer.
// Depends on opp_pkg, opp_cell and opp_seq.
//
// Takes one character per req transaction and returns one rsp transaction with
// a status and a reduction count. The symbol stack is a row of STACK_DEPTH cells
// that shift as one: a push moves every entry down by one, a three-symbol
// reduction moves them up by two, so every stack action is one update of the row.
// A character is handled in steps: it is accepted, then each reduction it triggers
// is one step, and a final shift or decision step registers its result.
// Characters are handled one at a time; the next is accepted in
// the cycle after the previous result is registered, even if that result has not
// yet been taken, but no reduction or decision step is made while an untaken
// result waits in the output register. The step limit is written through
// csr_wr_en and csr_wr_data and resets to 50.
module operator_precedence_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_symbol,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [opp_pkg::RED_W-1:0]     rsp_reductions,
   input  logic                          csr_wr_en,
   input  logic [opp_pkg::LIMIT_W-1:0]   csr_wr_data
);

   opp_pkg::cell_ctrl_type      ctrl;
   logic [opp_pkg::SYM_W-1:0]   stack_val [opp_pkg::STACK_DEPTH];

   opp_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_symbol     (req_symbol),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_reductions (rsp_reductions),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cell0          (stack_val[0]),
      .cell1          (stack_val[1]),
      .cell2          (stack_val[2]),
      .ctrl           (ctrl)
   );

   for (genvar k = 0; k < opp_pkg::STACK_DEPTH; k++) begin : g_cell
      logic [opp_pkg::SYM_W-1:0] up_val;
      logic [opp_pkg::SYM_W-1:0] down2_val;
      opp_pkg::cell_op_type      op;

      if (k == 0) begin : g_top
         assign up_val = ctrl.top_val;
         assign op     = ctrl.top_op;
      end else begin : g_rest
         assign up_val = stack_val[k-1];
         assign op     = ctrl.rest_op;
      end

      if (k + 2 < opp_pkg::STACK_DEPTH) begin : g_deep
         assign down2_val = stack_val[k+2];
      end else begin : g_last
         assign down2_val = stack_val[k];
      end

      opp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .up_val    (up_val),
         .down2_val (down2_val),
         .value     (stack_val[k])
      );
   end

endmodule
